>>> rtl/pfl_pkg.sv
// ----------------------------------------------------------------------------
// pfl_pkg
// Shared types, constants and the per-component fade step for the palette
// fade and lookup block.
// ----------------------------------------------------------------------------
package pfl_pkg;

   localparam int PAL_ENTRIES_DEF = 16;
   localparam int IDX_IN_W        = 4;
   localparam int COMP_W          = 8;
   localparam int RGB_W           = 3 * COMP_W;

   localparam logic [COMP_W-1:0] FADE_STEP_RST = 8'd16;

   // action code 3 is unused and falls to the default arm everywhere
   typedef enum logic [1:0] {
      ACT_WRITE  = 2'd0,
      ACT_FADE   = 2'd1,
      ACT_LOOKUP = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_LOOK    = 2'd1,
      ST_FADE_RD = 2'd2,
      ST_FADE_WR = 2'd3
   } state_type;

   typedef struct packed {
      logic tgt_we;    // write target entry from the request beat
      logic look_rd;   // read current entry at the request index
      logic fade_rd;   // read current and target at the walk counter
      logic fade_wr;   // write faded entry back at the walk counter
      logic rsp_load;  // load the response register
      logic cnt_clr;
      logic cnt_inc;
   } cmd_type;

   typedef struct packed {
      logic cnt_last;  // walk counter is at the last entry
      logic rsp_busy;  // response register full and not taken this cycle
   } sts_type;

   // move one component toward its target, landing on it when close enough
   function automatic logic [COMP_W-1:0] approach(input logic [COMP_W-1:0] cur,
                                                   input logic [COMP_W-1:0] tgt,
                                                   input logic [COMP_W-1:0] step);
      logic [COMP_W:0] up;
      logic [COMP_W:0] lim;
      logic [COMP_W-1:0] res;
      up  = {1'b0, cur} + {1'b0, step};
      lim = {1'b0, tgt} + {1'b0, step};
      if (cur < tgt) begin
         res = (up < {1'b0, tgt}) ? up[COMP_W-1:0] : tgt;
      end else if (cur > tgt) begin
         res = ({1'b0, cur} > lim) ? (cur - step) : tgt;
      end else begin
         res = cur;
      end
      return res;
   endfunction

endpackage

>>> rtl/palette_fade_and_lookup.sv
// ----------------------------------------------------------------------------
// palette_fade_and_lookup
// Current/target RGB palette with fade toward target and pixel lookup.
// ----------------------------------------------------------------------------
// Request beats carry an action in req_tuser: a target write is done as the
// beat is taken and the next beat may follow at once; a lookup starts the
// registered palette read as the beat is taken, then loads the response
// register in ST_LOOK, waiting there only while an earlier response is still
// held by the sink; a fade tick walks every entry through the single read/write
// port of the current palette memory, with a read and a write-back state per
// entry. The response register lets new request beats be taken while a lookup
// result waits. No clearing pass is needed after reset: never-written entries
// read as black through per-entry valid bits. The user must write fade_step
// through csr_we/csr_wdata while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module palette_fade_and_lookup import pfl_pkg::*; #(
   parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // entry_index, target_red, target_green, target_blue
   input  logic [1:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // red, green, blue
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata    // fade_step
);

   cmd_type cmd;
   sts_type sts;

   pfl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   pfl_dpath #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_entry_index (req_tdata[3:0]),
      .req_red         (req_tdata[11:4]),
      .req_green       (req_tdata[19:12]),
      .req_blue        (req_tdata[27:20]),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_rgb         (rsp_tdata)
   );

endmodule

>>> rtl/pfl_dpath.sv
// ----------------------------------------------------------------------------
// pfl_dpath
// Palette memories, fade walk counter, fade step register and the response
// register.
// ----------------------------------------------------------------------------
module pfl_dpath import pfl_pkg::*; #(
   parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic [IDX_IN_W-1:0] req_entry_index,
   input  logic [COMP_W-1:0]   req_red,
   input  logic [COMP_W-1:0]   req_green,
   input  logic [COMP_W-1:0]   req_blue,
   input  logic                csr_we,
   input  logic [COMP_W-1:0]   csr_wdata,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [RGB_W-1:0]    rsp_rgb
);

   localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int EXT_W = (IDX_W > IDX_IN_W) ? IDX_W : IDX_IN_W;

   logic [RGB_W-1:0]  cur_mem [PALETTE_ENTRIES];
   logic [RGB_W-1:0]  tgt_mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] cur_vld_ff;
   logic [PALETTE_ENTRIES-1:0] tgt_vld_ff;

   logic [EXT_W-1:0]  req_idx_ext;
   logic [IDX_W-1:0]  req_addr;
   logic              req_in_range;
   logic [IDX_W-1:0]  cur_addr;

   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic [COMP_W-1:0] step_ff;
   logic [RGB_W-1:0]  cur_rd_ff, tgt_rd_ff;
   logic              cur_rd_vld_ff, tgt_rd_vld_ff;
   logic              in_range_ff;
   logic [RGB_W-1:0]  cur_q, tgt_q, faded;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RGB_W-1:0]  rsp_rgb_ff;

   assign req_idx_ext  = EXT_W'(req_entry_index);
   assign req_addr     = req_idx_ext[IDX_W-1:0];
   assign req_in_range = (32'(req_entry_index) < 32'(PALETTE_ENTRIES));
   assign cur_addr     = cmd.look_rd ? req_addr : cnt_ff;

   // never-written entries read as black
   assign cur_q = cur_rd_vld_ff ? cur_rd_ff : '0;
   assign tgt_q = tgt_rd_vld_ff ? tgt_rd_ff : '0;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         faded[c*COMP_W +: COMP_W] = approach(cur_q[c*COMP_W +: COMP_W],
                                              tgt_q[c*COMP_W +: COMP_W], step_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tgt_we && req_in_range) begin
         tgt_mem[req_addr] <= {req_blue, req_green, req_red};
      end
      if (cmd.fade_rd) begin
         tgt_rd_ff     <= tgt_mem[cnt_ff];
         tgt_rd_vld_ff <= tgt_vld_ff[cnt_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fade_wr) begin
         cur_mem[cnt_ff] <= faded;
      end
      if (cmd.look_rd || cmd.fade_rd) begin
         cur_rd_ff     <= cur_mem[cur_addr];
         cur_rd_vld_ff <= cur_vld_ff[cur_addr];
      end
      if (cmd.look_rd) begin
         in_range_ff <= req_in_range;
      end
      if (cmd.rsp_load) begin
         rsp_rgb_ff <= in_range_ff ? cur_q : '0;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff   <= '0;
         tgt_vld_ff   <= '0;
         cnt_ff       <= '0;
         step_ff      <= FADE_STEP_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.tgt_we && req_in_range) begin
            tgt_vld_ff[req_addr] <= 1'b1;
         end
         if (cmd.fade_wr) begin
            cur_vld_ff[cnt_ff] <= 1'b1;
         end
         if (csr_we) begin
            step_ff <= csr_wdata;
         end
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.cnt_last = (cnt_ff == IDX_W'(PALETTE_ENTRIES - 1));
   assign sts.rsp_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_rgb      = rsp_rgb_ff;

endmodule

>>> rtl/pfl_ctrl.sv
// ----------------------------------------------------------------------------
// pfl_ctrl
// Sequencer: takes request beats, issues target writes, runs lookups and the
// fade walk over all palette entries.
// ----------------------------------------------------------------------------
module pfl_ctrl import pfl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  sts_type    sts,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      req_acc;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (action_type'(req_action))
                  ACT_FADE:   state_in = ST_FADE_RD;
                  ACT_LOOKUP: state_in = ST_LOOK;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOOK: begin
            if (!sts.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_FADE_RD: state_in = ST_FADE_WR;
         ST_FADE_WR: state_in = sts.cnt_last ? ST_IDLE : ST_FADE_RD;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (action_type'(req_action))
                  ACT_WRITE:  cmd.tgt_we  = 1'b1;
                  ACT_FADE:   cmd.cnt_clr = 1'b1;
                  ACT_LOOKUP: cmd.look_rd = 1'b1;
                  default:    cmd = '0;
               endcase
            end
         end
         ST_LOOK:    cmd.rsp_load = !sts.rsp_busy;
         ST_FADE_RD: cmd.fade_rd  = 1'b1;
         ST_FADE_WR: begin
            cmd.fade_wr = 1'b1;
            cmd.cnt_inc = !sts.cnt_last;
         end
         default:    cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_lookup_waits: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_action == ACT_LOOKUP) |=> (state_ff == ST_LOOK))
      else $error("lookup accept did not enter lookup wait");

   a_wr_after_rd: assert property (@(posedge clock) disable iff (reset)
      cmd.fade_wr |-> ($past(state_ff) == ST_FADE_RD))
      else $error("fade write-back without a preceding read");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !sts.rsp_busy)
      else $error("response register loaded while still held");

   a_fade_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FADE_WR) && sts.cnt_last |=> (state_ff == ST_IDLE))
      else $error("fade walk did not end after last entry");

endmodule
